// File: hw/rtl/ssd_pkg.sv
package ssd_pkg;

  localparam int unsigned NumDigits = 4;
  localparam int unsigned DigitIdxW = 2;
  localparam int unsigned SegW = 8;
  localparam int unsigned MagW = 14;

  typedef enum logic [1:0] {
    MODE_SIGNED   = 2'd0,
    MODE_UNSIGNED = 2'd1,
    MODE_SCAN     = 2'd2,
    MODE_UNUSED   = 2'd3
  } mode_t;

  localparam logic [SegW-1:0] SEG_MINUS = 8'h40;
  localparam logic [SegW-1:0] SEG_BLANK = 8'h00;
  localparam logic [SegW-1:0] SEG_RESET = 8'hff;
  localparam logic [MagW-1:0] SIGNED_MAX = 14'd999;
  localparam logic [MagW-1:0] UNSIGNED_MAX = 14'd9999;

  typedef logic [SegW-1:0] seg_t;

  typedef struct packed {
    logic en;
    seg_t [NumDigits-1:0] digits;
  } digit_wr_t;

  function automatic seg_t digit_font(input logic [3:0] d);
    seg_t s;
    case (d)
      4'd0: s = 8'h3f;
      4'd1: s = 8'h06;
      4'd2: s = 8'h5b;
      4'd3: s = 8'h4f;
      4'd4: s = 8'h66;
      4'd5: s = 8'h6d;
      4'd6: s = 8'h7d;
      4'd7: s = 8'h27;
      4'd8: s = 8'h7f;
      4'd9: s = 8'h67;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

// File: hw/rtl/ssd_if.sv
interface ssd_in_if;
  import ssd_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] mode;
  logic signed [16:0] value;
  logic [15:0] scan_count;

  modport source (output valid, mode, value, scan_count, input ready);
  modport sink (input valid, mode, value, scan_count, output ready);
endinterface

interface ssd_out_if;
  import ssd_pkg::*;
  logic valid;
  logic ready;
  seg_t segments;
  logic [NumDigits-1:0] digit_enable;

  modport source (output valid, segments, digit_enable, input ready);
  modport sink (input valid, segments, digit_enable, output ready);
endinterface

// File: hw/rtl/ssd_encode.sv
module ssd_encode
  import ssd_pkg::*;
(
  input  mode_t       mode,
  input  logic [15:0] raw,
  output digit_wr_t   wr
);

  logic [MagW-1:0] mag_s;
  logic [MagW-1:0] mag_u;
  logic [MagW-1:0] mag;
  logic [15:0] neg_raw;
  logic [26:0] prod10;
  logic [26:0] prod100;
  logic [27:0] prod1000;
  logic [10:0] q10;
  logic [7:0] q100;
  logic [4:0] q1000;
  logic [MagW-1:0] ones_w;
  logic [10:0] tens_w;
  logic [7:0] hund_w;
  seg_t f_thou, f_hund, f_tens, f_ones;
  seg_t lead;
  logic blank0, blank1, blank2;

  assign neg_raw = 16'd0 - raw;
  assign mag_s = (raw[15] ? (neg_raw > 16'(SIGNED_MAX)) : (raw > 16'(SIGNED_MAX)))
                 ? SIGNED_MAX
                 : (raw[15] ? neg_raw[MagW-1:0] : raw[MagW-1:0]);
  assign mag_u = (raw > 16'(UNSIGNED_MAX)) ? UNSIGNED_MAX : raw[MagW-1:0];
  assign mag = (mode == MODE_SIGNED) ? mag_s : mag_u;

  // reciprocal multiplies, exact for mag below 10000
  assign prod10   = {13'd0, mag} * 27'd6554;
  assign prod100  = {13'd0, mag} * 27'd5243;
  assign prod1000 = {14'd0, mag} * 28'd8389;
  assign q10   = prod10[26:16];
  assign q100  = prod100[26:19];
  assign q1000 = prod1000[27:23];

  assign ones_w = mag - ({3'd0, q10} * 14'd10);
  assign tens_w = q10 - ({3'd0, q100} * 11'd10);
  assign hund_w = q100 - ({3'd0, q1000} * 8'd10);

  assign f_thou = digit_font(q1000[3:0]);
  assign f_hund = digit_font(hund_w[3:0]);
  assign f_tens = digit_font(tens_w[3:0]);
  assign f_ones = digit_font(ones_w[3:0]);

  always_comb begin
    if (mode == MODE_SIGNED) begin
      lead = raw[15] ? SEG_MINUS : SEG_BLANK;
      blank0 = 1'b0;
      blank1 = (hund_w[3:0] == 4'd0);
    end else begin
      lead = f_thou;
      blank0 = (q1000 == 5'd0);
      blank1 = blank0 && (hund_w[3:0] == 4'd0);
    end
    blank2 = blank1 && (tens_w[3:0] == 4'd0);
    wr.en = (mode == MODE_SIGNED) || (mode == MODE_UNSIGNED);
    wr.digits[0] = blank0 ? SEG_BLANK : lead;
    wr.digits[1] = blank1 ? SEG_BLANK : f_hund;
    wr.digits[2] = blank2 ? SEG_BLANK : f_tens;
    wr.digits[3] = f_ones;
  end

endmodule

// File: hw/rtl/ssd_store.sv
module ssd_store
  import ssd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  digit_wr_t            wr,
  input  logic [DigitIdxW-1:0] rd_idx,
  output seg_t                 rd_data
);

  seg_t pat [NumDigits];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumDigits; i++) pat[i] <= SEG_RESET;
    end else if (wr.en) begin
      for (int i = 0; i < NumDigits; i++) pat[i] <= wr.digits[i];
    end
  end

  assign rd_data = pat[rd_idx];

endmodule

// File: hw/rtl/seven_segment_display_driver.sv
// Path: a scan tick is registered in the input stage, then its pattern in the output register once that is free.
// Throughput: one transaction per cycle unless a scan waits on a held result; value writes retire in the input stage.
// A value write updates the digit patterns at the edge after its acceptance.
// Reset (rst, synchronous): all digit patterns 0xff, both stages emptied.
module seven_segment_display_driver
  import ssd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  ssd_in_if.sink           item,
  ssd_out_if.source        result
);

  logic s1_valid;
  mode_t s1_mode;
  logic [15:0] s1_raw;
  logic [DigitIdxW-1:0] s1_idx;
  logic s1_scan;
  logic out_free;
  logic s1_adv;
  logic out_valid;
  seg_t out_seg;
  logic [NumDigits-1:0] out_en;
  digit_wr_t enc_wr;
  digit_wr_t st_wr;
  seg_t rd_data;

  assign s1_scan = (s1_mode == MODE_SCAN);
  assign out_free = !out_valid || result.ready;
  assign s1_adv = s1_valid && (!s1_scan || out_free);
  assign item.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
    if (item.valid && item.ready) begin
      s1_mode <= mode_t'(item.mode);
      s1_raw <= item.value[15:0];
      s1_idx <= item.scan_count[DigitIdxW-1:0];
    end
  end

  ssd_encode u_encode (
    .mode (s1_mode),
    .raw  (s1_raw),
    .wr   (enc_wr)
  );

  always_comb begin
    st_wr = enc_wr;
    st_wr.en = enc_wr.en && s1_valid;
  end

  ssd_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (st_wr),
    .rd_idx  (s1_idx),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_scan) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_adv && s1_scan) begin
      out_seg <= rd_data;
      out_en <= NumDigits'(1) << s1_idx;
    end
  end

  assign result.valid = out_valid;
  assign result.segments = out_seg;
  assign result.digit_enable = out_en;

  a_enable_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot(out_en))
    else $error("digit enable not one-hot");

  a_scan_blocks: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_scan && out_valid && !result.ready) |-> !item.ready)
    else $error("input taken while scan result is blocked");

  a_scan_lands: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_scan) |=> out_valid)
    else $error("scan result lost");

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_scan && !out_valid) |=> !out_valid)
    else $error("value write produced a result");

endmodule

// File: test/tb_seven_segment_display_driver.sv
`timescale 1ns / 1ps

module tb_seven_segment_display_driver;
  import ssd_pkg::*;

  localparam int unsigned CycleLimit = 60000;
  localparam int unsigned RandomItems = 550;
  localparam int unsigned MaxReports = 10;
  // glyphs for 9..0, digit d sits at bits [8*d +: 8]
  localparam logic [79:0] Glyphs = {8'h67, 8'h7f, 8'h27, 8'h7d, 8'h6d,
                                    8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f};

  typedef struct {
    seg_t segments;
    logic [NumDigits-1:0] digit_enable;
  } scan_out_t;

  logic clk = 1'b0;
  logic rst;
  bit steady = 1'b0;
  int unsigned cycles = 0;
  int unsigned mismatches = 0;

  seg_t shown_digits [NumDigits];
  scan_out_t pending_scans [$];

  ssd_in_if item_bus ();
  ssd_out_if result_bus ();

  seven_segment_display_driver uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (result_bus)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic seg_t glyph(input int unsigned d);
    return Glyphs[8*d +: 8];
  endfunction

  // lead goes to digit 0; leading zeros are blanked from digit first_blank up to digit 2
  function automatic void load_display(input seg_t lead, input int unsigned mag,
                                       input int unsigned first_blank);
    seg_t d [NumDigits];
    logic blanking;
    d[0] = lead;
    d[1] = glyph((mag / 100) % 10);
    d[2] = glyph((mag / 10) % 10);
    d[3] = glyph(mag % 10);
    blanking = 1'b1;
    for (int unsigned i = first_blank; i < 3; i++) begin
      if (blanking && d[i] == glyph(0)) begin
        d[i] = SEG_BLANK;
      end else begin
        blanking = 1'b0;
      end
    end
    for (int i = 0; i < NumDigits; i++) shown_digits[i] = d[i];
  endfunction

  function automatic void apply_display_item(input mode_t m, input logic signed [16:0] v,
                                             input logic [15:0] sc);
    logic [15:0] raw;
    int unsigned mag;
    scan_out_t s;
    raw = v[15:0];
    mag = raw;
    case (m)
      MODE_SIGNED: begin
        if (raw[15]) mag = 32'h10000 - raw;
        if (mag > SIGNED_MAX) mag = SIGNED_MAX;
        load_display(raw[15] ? SEG_MINUS : SEG_BLANK, mag, 1);
      end
      MODE_UNSIGNED: begin
        if (mag > UNSIGNED_MAX) mag = UNSIGNED_MAX;
        load_display(glyph((mag / 1000) % 10), mag, 0);
      end
      MODE_SCAN: begin
        s.segments = shown_digits[sc[DigitIdxW-1:0]];
        s.digit_enable = 4'b0001 << sc[DigitIdxW-1:0];
        pending_scans.push_back(s);
      end
      default: ;
    endcase
  endfunction

  function automatic void check_scan();
    scan_out_t want;
    if (pending_scans.size() == 0) begin
      mismatches++;
      if (mismatches <= MaxReports)
        $display("unexpected result: segments %h enable %b",
                 result_bus.segments, result_bus.digit_enable);
      return;
    end
    want = pending_scans.pop_front();
    if (result_bus.segments !== want.segments) begin
      mismatches++;
      if (mismatches <= MaxReports)
        $display("segments mismatch: expected %h got %h", want.segments,
                 result_bus.segments);
    end
    if (result_bus.digit_enable !== want.digit_enable) begin
      mismatches++;
      if (mismatches <= MaxReports)
        $display("digit_enable mismatch: expected %b got %b", want.digit_enable,
                 result_bus.digit_enable);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      result_bus.ready <= 1'b0;
    end else begin
      if (result_bus.valid && result_bus.ready) check_scan();
      result_bus.ready <= steady || ($urandom_range(0, 99) >= 7);
    end
  end

  // returns at the edge that accepts the transaction, valid still high
  task automatic send_item(input mode_t m, input logic signed [16:0] v,
                           input logic [15:0] sc);
    while (!steady && $urandom_range(0, 99) < 7) begin
      item_bus.valid <= 1'b0;
      @(posedge clk);
    end
    item_bus.valid <= 1'b1;
    item_bus.mode <= m;
    item_bus.value <= v;
    item_bus.scan_count <= sc;
    do @(posedge clk); while (!item_bus.ready);
    apply_display_item(m, v, sc);
  endtask

  function automatic logic [15:0] scan_at(input int unsigned idx);
    return {14'($urandom_range(0, 16'h3fff)), 2'(idx)};
  endfunction

  task automatic write_and_scan(input mode_t m, input logic signed [16:0] v);
    send_item(m, v, 16'h0000);
    for (int i = 0; i < NumDigits; i++) send_item(MODE_SCAN, 17'($urandom), scan_at(i));
  endtask

  task automatic wait_drained();
    item_bus.valid <= 1'b0;
    while (pending_scans.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [16:0] pick_value();
    int x;
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 19))
          0: x = 0;       1: x = 1;       2: x = 9;       3: x = 10;
          4: x = 99;      5: x = 100;     6: x = 999;     7: x = 1000;
          8: x = 9999;    9: x = 10000;   10: x = 32767;  11: x = 65535;
          12: x = -1;     13: x = -9;     14: x = -10;    15: x = -100;
          16: x = -999;   17: x = -1000;  18: x = -32768; default: x = 1001;
        endcase
      end
      1: x = $urandom_range(0, 1100);
      2: x = -int'($urandom_range(1, 1100));
      default: x = $urandom_range(0, 1) ? int'($urandom_range(0, 65535))
                                        : -int'($urandom_range(1, 32768));
    endcase
    return x[16:0];
  endfunction

  task automatic test_reset_patterns();
    for (int i = 0; i < NumDigits; i++) send_item(MODE_SCAN, 17'($urandom), scan_at(i));
  endtask

  task automatic test_signed_writes();
    write_and_scan(MODE_SIGNED, -17'sd1000);
    write_and_scan(MODE_SIGNED, 17'sd42);
  endtask

  task automatic test_unsigned_writes();
    write_and_scan(MODE_UNSIGNED, 17'sd1234);
    write_and_scan(MODE_UNSIGNED, 17'sd65535);
  endtask

  task automatic test_unused_mode();
    send_item(MODE_UNUSED, -17'sd1, 16'hffff);
    send_item(MODE_SCAN, 17'sd0, scan_at(3));
  endtask

  // sender holds off until every scan result is back
  task automatic test_drain_pause();
    write_and_scan(MODE_SIGNED, -17'sd32768);
    wait_drained();
    write_and_scan(MODE_UNSIGNED, 17'sd0);
  endtask

  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned n;
    sent = 0;
    while (sent < RandomItems) begin
      steady = (sent >= 200 && sent < 350);
      if ($urandom_range(0, 99) < 10) begin
        if ($urandom_range(0, 1)) begin
          send_item(MODE_UNUSED, 17'($urandom), 16'($urandom));
        end else begin
          send_item(MODE_SCAN, 17'($urandom), 16'($urandom));
          sent++;
        end
      end else begin
        send_item($urandom_range(0, 1) ? MODE_SIGNED : MODE_UNSIGNED, pick_value(),
                  16'($urandom));
        n = $urandom_range(1, 4);
        for (int unsigned k = 0; k < n; k++)
          send_item(MODE_SCAN, 17'($urandom), 16'($urandom));
        sent += 1 + n;
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst <= 1'b1;
    item_bus.valid <= 1'b0;
    item_bus.mode <= MODE_UNUSED;
    item_bus.value <= '0;
    item_bus.scan_count <= '0;
    for (int i = 0; i < NumDigits; i++) shown_digits[i] = SEG_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_patterns();
    test_signed_writes();
    test_unsigned_writes();
    test_unused_mode();
    test_drain_pause();
    test_random_traffic();

    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/ssd_pkg.sv
hw/rtl/ssd_if.sv
hw/rtl/ssd_encode.sv
hw/rtl/ssd_store.sv
hw/rtl/seven_segment_display_driver.sv
test/tb_seven_segment_display_driver.sv
